// File: rtl/mlr_pkg.sv
package mlr_pkg;

	localparam int COORD_BITS = 20;
	localparam int MAX_RESOLUTION = 4096;

	localparam int CFG_W = 16;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int EDGE_W = DIFF_W + CFG_W;
	localparam int OPW = ((2 * EDGE_W + 1) + 3) / 4 * 4;
	localparam int PRODW = 2 * OPW;
	localparam int NDIG_MAX = OPW / 4;
	localparam int DIG_W = $clog2(NDIG_MAX + 1);
	localparam int ROOT_W = OPW;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQ_CNT_W = $clog2(ROOT_W + 1);
	localparam int AREA_W = 63;
	localparam int AREA_SHIFT = 17;
	localparam int FROOT_W = 32;
	localparam int RES_W = $clog2(MAX_RESOLUTION) + 1;
	localparam int IN_W = ((9 * COORD_BITS) + 7) / 8 * 8;
	localparam int OUT_FIELDS_W = AREA_W + 2 * RES_W;
	localparam int OUT_W = (OUT_FIELDS_W + 7) / 8 * 8;
	localparam int PC_W = 4;
	localparam int ADDR_W = 4;

	localparam logic [DIG_W-1:0] SDIG = DIG_W'(CFG_W / 4);
	localparam logic [DIG_W-1:0] EDIG = DIG_W'((EDGE_W + 3) / 4);
	localparam logic [DIG_W-1:0] CDIG = DIG_W'(NDIG_MAX);

	localparam logic [PC_W-1:0] LAST_TRI_PC = PC_W'(14);
	localparam logic [PC_W-1:0] FIN_PC = PC_W'(15);

	localparam logic [1:0] REG_DENSITY = 2'd0;
	localparam logic [1:0] REG_SCALE_X = 2'd1;
	localparam logic [1:0] REG_SCALE_Y = 2'd2;
	localparam logic [1:0] REG_SCALE_Z = 2'd3;

	typedef enum logic [4:0] {
		SRC_DAX, SRC_DAY, SRC_DAZ, SRC_DBX, SRC_DBY, SRC_DBZ,
		SRC_SX, SRC_SY, SRC_SZ,
		SRC_EAX, SRC_EAY, SRC_EAZ, SRC_EBX, SRC_EBY, SRC_EBZ,
		SRC_C, SRC_AREA, SRC_DEN
	} src_t;

	typedef enum logic [3:0] {
		DST_EAX, DST_EAY, DST_EAZ, DST_EBX, DST_EBY, DST_EBZ,
		DST_P, DST_C, DST_S, DST_SADD
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		dst_t dst;
		logic [DIG_W-1:0] ndig;
	} uop_t;

	typedef struct packed {
		logic load;
		logic mul_go;
		logic wr;
		logic sq_go;
		logic acc;
		logic emit;
		uop_t op;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic sq_busy;
		logic last;
		logic out_busy;
	} sts_t;

	typedef struct packed {
		logic [CFG_W-1:0] density;
		logic [CFG_W-1:0] scale_x;
		logic [CFG_W-1:0] scale_y;
		logic [CFG_W-1:0] scale_z;
	} cfg_t;

	function automatic uop_t uop(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			4'd0: u = '{SRC_DAX, SRC_SX, DST_EAX, SDIG};
			4'd1: u = '{SRC_DAY, SRC_SY, DST_EAY, SDIG};
			4'd2: u = '{SRC_DAZ, SRC_SZ, DST_EAZ, SDIG};
			4'd3: u = '{SRC_DBX, SRC_SX, DST_EBX, SDIG};
			4'd4: u = '{SRC_DBY, SRC_SY, DST_EBY, SDIG};
			4'd5: u = '{SRC_DBZ, SRC_SZ, DST_EBZ, SDIG};
			4'd6: u = '{SRC_EAY, SRC_EBZ, DST_P, EDIG};
			4'd7: u = '{SRC_EAZ, SRC_EBY, DST_C, EDIG};
			4'd8: u = '{SRC_C, SRC_C, DST_S, CDIG};
			4'd9: u = '{SRC_EAZ, SRC_EBX, DST_P, EDIG};
			4'd10: u = '{SRC_EAX, SRC_EBZ, DST_C, EDIG};
			4'd11: u = '{SRC_C, SRC_C, DST_SADD, CDIG};
			4'd12: u = '{SRC_EAX, SRC_EBY, DST_P, EDIG};
			4'd13: u = '{SRC_EAY, SRC_EBX, DST_C, EDIG};
			4'd14: u = '{SRC_C, SRC_C, DST_SADD, CDIG};
			default: u = '{SRC_AREA, SRC_DEN, DST_S, SDIG};
		endcase
		return u;
	endfunction

endpackage

// File: rtl/mlr_regs.sv
module mlr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mlr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mlr_pkg::cfg_t               cfg
);

	mlr_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.density <= 16'd256;
			cfg_q.scale_x <= 16'd256;
			cfg_q.scale_y <= 16'd256;
			cfg_q.scale_z <= 16'd256;
		end else if (wr_en) begin
			case (paddr[3:2])
				mlr_pkg::REG_DENSITY: cfg_q.density <= pwdata[15:0];
				mlr_pkg::REG_SCALE_X: cfg_q.scale_x <= pwdata[15:0];
				mlr_pkg::REG_SCALE_Y: cfg_q.scale_y <= pwdata[15:0];
				mlr_pkg::REG_SCALE_Z: cfg_q.scale_z <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mlr_pkg::REG_DENSITY: prdata = {16'd0, cfg_q.density};
			mlr_pkg::REG_SCALE_X: prdata = {16'd0, cfg_q.scale_x};
			mlr_pkg::REG_SCALE_Y: prdata = {16'd0, cfg_q.scale_y};
			mlr_pkg::REG_SCALE_Z: prdata = {16'd0, cfg_q.scale_z};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/mlr_dp.sv
module mlr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mlr_pkg::cfg_t               cfg,
	input  mlr_pkg::cmd_t               cmd,
	output mlr_pkg::sts_t               sts,
	input  logic [mlr_pkg::IN_W-1:0]    in_data,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mlr_pkg::OUT_W-1:0]   out_data
);

	localparam int CB = mlr_pkg::COORD_BITS;
	localparam int DW = mlr_pkg::DIFF_W;
	localparam int EW = mlr_pkg::EDGE_W;
	localparam int OPW = mlr_pkg::OPW;
	localparam int PW = mlr_pkg::PRODW;
	localparam int RW = mlr_pkg::ROOT_W;
	localparam int MW = mlr_pkg::REM_W;
	localparam int AW = mlr_pkg::AREA_W;
	localparam int RSW = mlr_pkg::RES_W;
	localparam int FW = mlr_pkg::FROOT_W;
	localparam int TW = RW - mlr_pkg::AREA_SHIFT;
	localparam int CW = mlr_pkg::CFG_W;

	logic signed [DW-1:0] d_q [6];
	logic signed [EW-1:0] e_q [6];
	logic signed [OPW-1:0] p_q, c_q;
	logic [PW-1:0] s_q, acc_q;
	logic [OPW-1:0] ma_q, mb_q;
	logic neg_q, mul_busy_q, last_q;
	logic [mlr_pkg::DIG_W-1:0] mcnt_q;
	logic [MW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [mlr_pkg::SQ_CNT_W-1:0] scnt_q;
	logic sq_busy_q;
	logic [AW-1:0] area_q;
	logic out_valid_q;
	logic [AW-1:0] out_area_q;
	logic [RSW-1:0] out_res_q, out_min_q;

	logic signed [OPW-1:0] a_s, b_s, a_mag, b_mag;
	logic [mlr_pkg::DIG_W-1:0] skip;
	logic [PW-1:0] prod;
	logic [OPW+3:0] part;
	logic [MW-1:0] rem2, trial;
	logic [AW:0] sum;
	logic [FW-1:0] rt;
	logic [RSW-1:0] res, pw2, minres;
	logic [RSW+1:0] r2, p3;

	function automatic logic signed [OPW-1:0] sx_d(input logic signed [DW-1:0] v);
		return {{(OPW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [OPW-1:0] sx_e(input logic signed [EW-1:0] v);
		return {{(OPW-EW){v[EW-1]}}, v};
	endfunction

	function automatic logic signed [OPW-1:0] pick(input mlr_pkg::src_t s,
			input logic signed [DW-1:0] d0, input logic signed [DW-1:0] d1,
			input logic signed [DW-1:0] d2, input logic signed [DW-1:0] d3,
			input logic signed [DW-1:0] d4, input logic signed [DW-1:0] d5,
			input logic signed [EW-1:0] e0, input logic signed [EW-1:0] e1,
			input logic signed [EW-1:0] e2, input logic signed [EW-1:0] e3,
			input logic signed [EW-1:0] e4, input logic signed [EW-1:0] e5,
			input logic signed [OPW-1:0] c, input logic [AW-1:0] ar,
			input mlr_pkg::cfg_t cf);
		logic signed [OPW-1:0] v;
		case (s)
			mlr_pkg::SRC_DAX: v = sx_d(d0);
			mlr_pkg::SRC_DAY: v = sx_d(d1);
			mlr_pkg::SRC_DAZ: v = sx_d(d2);
			mlr_pkg::SRC_DBX: v = sx_d(d3);
			mlr_pkg::SRC_DBY: v = sx_d(d4);
			mlr_pkg::SRC_DBZ: v = sx_d(d5);
			mlr_pkg::SRC_SX: v = {{(OPW-CW){1'b0}}, cf.scale_x};
			mlr_pkg::SRC_SY: v = {{(OPW-CW){1'b0}}, cf.scale_y};
			mlr_pkg::SRC_SZ: v = {{(OPW-CW){1'b0}}, cf.scale_z};
			mlr_pkg::SRC_EAX: v = sx_e(e0);
			mlr_pkg::SRC_EAY: v = sx_e(e1);
			mlr_pkg::SRC_EAZ: v = sx_e(e2);
			mlr_pkg::SRC_EBX: v = sx_e(e3);
			mlr_pkg::SRC_EBY: v = sx_e(e4);
			mlr_pkg::SRC_EBZ: v = sx_e(e5);
			mlr_pkg::SRC_C: v = c;
			mlr_pkg::SRC_AREA: v = {{(OPW-AW){1'b0}}, ar};
			mlr_pkg::SRC_DEN: v = {{(OPW-CW){1'b0}}, cf.density};
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [DW-1:0] coord(input logic [CB-1:0] v);
		return {v[CB-1], v};
	endfunction

	// operand select and multiplier front end
	always_comb begin
		a_s = pick(cmd.op.a, d_q[0], d_q[1], d_q[2], d_q[3], d_q[4], d_q[5],
			e_q[0], e_q[1], e_q[2], e_q[3], e_q[4], e_q[5], c_q, area_q, cfg);
		b_s = pick(cmd.op.b, d_q[0], d_q[1], d_q[2], d_q[3], d_q[4], d_q[5],
			e_q[0], e_q[1], e_q[2], e_q[3], e_q[4], e_q[5], c_q, area_q, cfg);
		a_mag = a_s[OPW-1] ? -a_s : a_s;
		b_mag = b_s[OPW-1] ? -b_s : b_s;
		skip = mlr_pkg::DIG_W'(mlr_pkg::NDIG_MAX) - cmd.op.ndig;
		part = ma_q * mb_q[OPW-1:OPW-4];
		prod = neg_q ? (~acc_q + PW'(1)) : acc_q;
	end

	// multiplier, four bits of the second operand per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
		end else if (cmd.mul_go) begin
			mul_busy_q <= 1'b1;
		end else if (mul_busy_q && mcnt_q == mlr_pkg::DIG_W'(1)) begin
			mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			ma_q <= a_mag;
			mb_q <= b_mag << {skip, 2'b00};
			neg_q <= a_s[OPW-1] ^ b_s[OPW-1];
			acc_q <= '0;
			mcnt_q <= cmd.op.ndig;
		end else if (mul_busy_q) begin
			acc_q <= (acc_q << 4) + {{(PW-OPW-4){1'b0}}, part};
			mb_q <= mb_q << 4;
			mcnt_q <= mcnt_q - mlr_pkg::DIG_W'(1);
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q[0] <= coord(in_data[4*CB-1:3*CB]) - coord(in_data[CB-1:0]);
			d_q[1] <= coord(in_data[5*CB-1:4*CB]) - coord(in_data[2*CB-1:CB]);
			d_q[2] <= coord(in_data[6*CB-1:5*CB]) - coord(in_data[3*CB-1:2*CB]);
			d_q[3] <= coord(in_data[7*CB-1:6*CB]) - coord(in_data[CB-1:0]);
			d_q[4] <= coord(in_data[8*CB-1:7*CB]) - coord(in_data[2*CB-1:CB]);
			d_q[5] <= coord(in_data[9*CB-1:8*CB]) - coord(in_data[3*CB-1:2*CB]);
			last_q <= in_last;
		end
		if (cmd.wr) begin
			case (cmd.op.dst)
				mlr_pkg::DST_EAX: e_q[0] <= prod[EW-1:0];
				mlr_pkg::DST_EAY: e_q[1] <= prod[EW-1:0];
				mlr_pkg::DST_EAZ: e_q[2] <= prod[EW-1:0];
				mlr_pkg::DST_EBX: e_q[3] <= prod[EW-1:0];
				mlr_pkg::DST_EBY: e_q[4] <= prod[EW-1:0];
				mlr_pkg::DST_EBZ: e_q[5] <= prod[EW-1:0];
				mlr_pkg::DST_P: p_q <= prod[OPW-1:0];
				mlr_pkg::DST_C: c_q <= p_q - prod[OPW-1:0];
				mlr_pkg::DST_S: s_q <= prod;
				mlr_pkg::DST_SADD: s_q <= s_q + prod;
				default: ;
			endcase
		end else if (sq_busy_q) begin
			s_q <= s_q << 2;
		end
	end

	// square root, one result bit per cycle
	always_comb begin
		rem2 = {rem_q[MW-3:0], s_q[PW-1:PW-2]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
		end else if (cmd.sq_go) begin
			sq_busy_q <= 1'b1;
		end else if (sq_busy_q && scnt_q == mlr_pkg::SQ_CNT_W'(RW - 1)) begin
			sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_go) begin
			rem_q <= '0;
			root_q <= '0;
			scnt_q <= '0;
		end else if (sq_busy_q) begin
			scnt_q <= scnt_q + mlr_pkg::SQ_CNT_W'(1);
			if (rem2 >= trial) begin
				rem_q <= rem2 - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	// saturating area sum
	assign sum = {1'b0, area_q} + {{(AW+1-TW){1'b0}}, root_q[RW-1:mlr_pkg::AREA_SHIFT]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
		end else if (cmd.acc) begin
			area_q <= sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
		end else if (cmd.emit) begin
			area_q <= '0;
		end
	end

	// resolution and its bracketing power of two
	always_comb begin
		logic [FW-1:0] rc;
		rt = root_q[FW+7:8];
		if (rt > FW'(mlr_pkg::MAX_RESOLUTION)) begin
			rc = FW'(mlr_pkg::MAX_RESOLUTION);
		end else if (rt < FW'(4)) begin
			rc = FW'(4);
		end else begin
			rc = rt;
		end
		res = {rc[RSW-1:2], 2'b00};
		pw2 = '0;
		for (int i = 0; i < RSW; i++) begin
			if (res[i]) begin
				pw2 = RSW'(1) << i;
			end
		end
		r2 = {1'b0, res, 1'b0};
		p3 = {2'b00, pw2} + {1'b0, pw2, 1'b0};
		minres = (r2 < p3) ? (pw2 >> 1) : pw2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_area_q <= area_q;
			out_res_q <= res;
			out_min_q <= minres;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = {{(mlr_pkg::OUT_W-mlr_pkg::OUT_FIELDS_W){1'b0}},
		out_min_q, out_res_q, out_area_q};

	assign sts.mul_busy = mul_busy_q;
	assign sts.sq_busy = sq_busy_q;
	assign sts.last = last_q;
	assign sts.out_busy = out_valid_q & ~out_ready;

endmodule

// File: rtl/mlr_ctrl.sv
module mlr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mlr_pkg::sts_t   sts,
	output mlr_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MGO, ST_MRUN, ST_SQGO, ST_SQRUN, ST_OUT
	} state_t;

	state_t state_q;
	logic [mlr_pkg::PC_W-1:0] pc_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.op = mlr_pkg::uop(pc_q);
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MGO: cmd.mul_go = 1'b1;
			ST_MRUN: cmd.wr = ~sts.mul_busy;
			ST_SQGO: cmd.sq_go = 1'b1;
			ST_SQRUN: cmd.acc = ~sts.sq_busy & (pc_q == mlr_pkg::LAST_TRI_PC);
			ST_OUT: cmd.emit = ~sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pc_q <= '0;
						state_q <= ST_MGO;
					end
				end
				ST_MGO: state_q <= ST_MRUN;
				ST_MRUN: begin
					if (!sts.mul_busy) begin
						if (pc_q == mlr_pkg::LAST_TRI_PC || pc_q == mlr_pkg::FIN_PC) begin
							state_q <= ST_SQGO;
						end else begin
							pc_q <= pc_q + mlr_pkg::PC_W'(1);
							state_q <= ST_MGO;
						end
					end
				end
				ST_SQGO: state_q <= ST_SQRUN;
				ST_SQRUN: begin
					if (!sts.sq_busy) begin
						if (pc_q == mlr_pkg::FIN_PC) begin
							state_q <= ST_OUT;
						end else if (sts.last) begin
							pc_q <= mlr_pkg::FIN_PC;
							state_q <= ST_MGO;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/mesh_area_lightmap_resolution_unit.sv
// channel   dir  beat contents
// s_axis    in   tdata: 9 vertex coordinates, tlast: final triangle
// m_axis    out  tdata: surface_area, resolution, min_resolution
// apb       in   density, scale_x, scale_y, scale_z at 0x0, 0x4, 0x8, 0xc
//
// one triangle at a time: fifteen passes through a shared 4-bit-per-cycle
// multiplier, then a bit-serial square root
// the final triangle adds a multiplier pass and a second square root for the resolution
// the result sits in an output register, so the next triangle is taken while it waits
// reset clears the area sum and sets every apb register to 1.0
module mesh_area_lightmap_resolution_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// corner_x, corner_y, corner_z, second_x, second_y, second_z,
	// third_x, third_y, third_z
	input  logic [mlr_pkg::IN_W-1:0]    s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// surface_area, resolution, min_resolution
	output logic [mlr_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mlr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	mlr_pkg::cfg_t cfg;
	mlr_pkg::cmd_t cmd;
	mlr_pkg::sts_t sts;

	mlr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mlr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
